FILE: sv/cwic_pkg.sv
// ----------------------------------------------------------------------------
// cwic_pkg
// shared types, codes and arithmetic helpers for the w-intermediate core
// ----------------------------------------------------------------------------
package cwic_pkg;

  localparam int SPIN_ORBITALS_DEF = 16;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int IDX_W             = 4;
  localparam int DATA_W            = 32;
  localparam int ACC_W             = 64;
  localparam int FRAC_W            = 24;
  localparam int MASK_W            = 8;
  localparam int OP_W              = 3;
  localparam int KIND_W            = 2;

  localparam logic [OP_W-1:0] OP_WR_INT  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_SGL  = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_DBL  = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_TAU  = 3'd3;
  localparam logic [OP_W-1:0] OP_COMPUTE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_MNIJ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABEF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBEJ = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [ACC_W-1:0] HALF_LSB  = 64'sd8388608;

  typedef enum logic [3:0] {
    DP_NOP, DP_WRITE, DP_LOAD, DP_SCAN, DP_INIT, DP_MUL, DP_CAP, DP_MUL_T1,
    DP_COEF, DP_MUL_C, DP_ACC, DP_FINAL, DP_RND, DP_SAT, DP_ERR, DP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    TERM_BASE, TERM_S1, TERM_S2, TERM_TAU, TERM_F, TERM_CF, TERM_N
  } term_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_BASE_RD, ST_INIT, ST_OUTER, ST_T_RD,
    ST_T_MUL, ST_T_ACC, ST_INNER, ST_C_RD1, ST_C_RD2, ST_C_MUL1, ST_C_COEF,
    ST_C_MUL2, ST_FINAL, ST_RND, ST_SAT, ST_ERR, ST_FINISH
  } st_t;

  typedef struct packed {
    dp_op_t           op;
    term_t            term;
    logic             neg;
    logic             to_q;
    logic             sub;
    logic [IDX_W-1:0] outer_idx;
    logic [IDX_W-1:0] outer_cmp;
    logic [IDX_W-1:0] inner_idx;
    logic [IDX_W-1:0] inner_cmp;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              occ_outer;
    logic              occ_inner;
    logic              found_all;
    logic              out_busy;
  } status_t;

  // saturating 64-bit add
  function automatic logic signed [ACC_W-1:0] sadd64(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

endpackage

FILE: sv/cwic_dp.sv
// ----------------------------------------------------------------------------
// cwic_dp
// datapath: the four stores, orbital scan, multiplier and saturating sums
// ----------------------------------------------------------------------------
module cwic_dp #(
  parameter int VALUE_BITS = cwic_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwic_pkg::MASK_W-1:0]   cfg_wdata,
  input  logic [cwic_pkg::OP_W-1:0]     in_operation,
  input  logic [cwic_pkg::KIND_W-1:0]   in_formula_kind,
  input  logic [cwic_pkg::IDX_W-1:0]    in_idx_first,
  input  logic [cwic_pkg::IDX_W-1:0]    in_idx_second,
  input  logic [cwic_pkg::IDX_W-1:0]    in_idx_third,
  input  logic [cwic_pkg::IDX_W-1:0]    in_idx_fourth,
  input  logic signed [cwic_pkg::DATA_W-1:0] in_data_value,
  input  cwic_pkg::cmd_t                cmd,
  output cwic_pkg::status_t             status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [cwic_pkg::DATA_W-1:0] out_w_value,
  output logic                          out_status
);

  localparam int IW  = cwic_pkg::IDX_W;
  localparam int DW  = cwic_pkg::DATA_W;
  localparam int AW  = cwic_pkg::ACC_W;
  localparam int A4W = 4 * IW;
  localparam int A2W = 2 * IW;
  localparam int D4  = 1 << A4W;
  localparam int D2  = 1 << A2W;
  localparam logic [AW-1:0] SAT_HI_U = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);
  localparam logic signed [AW-1:0] SAT_HI = $signed(SAT_HI_U);
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [AW-1:0] C32_HI = 64'sd2147483647;
  localparam logic signed [AW-1:0] C32_LO = -64'sd2147483648;

  logic [DW-1:0] int_mem [D4];
  logic [DW-1:0] sgl_mem [D2];
  logic [DW-1:0] dbl_mem [D4];
  logic [DW-1:0] tau_mem [D4];
  logic signed [DW-1:0] int_q, sgl_q, dbl_q, tau_q;

  logic [cwic_pkg::MASK_W-1:0] mask_r;
  logic [cwic_pkg::KIND_W-1:0] kind_r;
  logic [IW-1:0] x_r [4];
  logic [IW-1:0] p_r [4];
  logic [3:0]    found_r;
  logic [IW:0]   occ_cnt_r, virt_cnt_r;

  logic signed [AW-1:0] acc_r, q_r, prod_r;
  logic signed [DW-1:0] t2_r, t1a_r, int_r, c24_r, res_r;
  logic                 err_r, out_valid_r;

  logic [A4W-1:0] int_ra, tau_ra, dbl_ra, wa4;
  logic [A2W-1:0] sgl_ra, wa2;
  logic           wr;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] mul_p, addend, coef, coef_sh, rnd_sh;
  logic           scan_occ;

  function automatic logic is_occ(input logic [IW-1:0] p, input logic [7:0] m);
    return m[p[IW-1:1]];
  endfunction

  // wanted orbital kind of each compact slot
  function automatic logic slot_occ(input logic [1:0] k, input int s);
    if (k == cwic_pkg::KIND_MNIJ) return 1'b1;
    if (k == cwic_pkg::KIND_MBEJ) return (s == 0) || (s == 3);
    return 1'b0;
  endfunction

  assign wr  = (cmd.op == cwic_pkg::DP_WRITE);
  assign wa4 = {in_idx_first, in_idx_second, in_idx_third, in_idx_fourth};
  assign wa2 = {in_idx_first, in_idx_second};

  always_comb begin
    int_ra = {p_r[0], p_r[1], p_r[2], p_r[3]};
    sgl_ra = {x_r[3], cmd.outer_cmp};
    tau_ra = {x_r[2], x_r[3], cmd.outer_cmp, cmd.inner_cmp};
    dbl_ra = {x_r[3], cmd.inner_cmp, cmd.outer_cmp, x_r[1]};
    unique case (kind_r)
      cwic_pkg::KIND_MNIJ: begin
        case (cmd.term)
          cwic_pkg::TERM_S1:  int_ra = {p_r[0], p_r[1], p_r[2], cmd.outer_idx};
          cwic_pkg::TERM_S2:  int_ra = {p_r[0], p_r[1], p_r[3], cmd.outer_idx};
          cwic_pkg::TERM_TAU: int_ra = {p_r[0], p_r[1], cmd.outer_idx, cmd.inner_idx};
          default: ;
        endcase
        sgl_ra = (cmd.term == cwic_pkg::TERM_S2) ? {x_r[2], cmd.outer_cmp}
                                                 : {x_r[3], cmd.outer_cmp};
      end
      cwic_pkg::KIND_ABEF: begin
        case (cmd.term)
          cwic_pkg::TERM_S1:  int_ra = {p_r[0], cmd.outer_idx, p_r[2], p_r[3]};
          cwic_pkg::TERM_S2:  int_ra = {p_r[1], cmd.outer_idx, p_r[2], p_r[3]};
          cwic_pkg::TERM_TAU: int_ra = {cmd.outer_idx, cmd.inner_idx, p_r[2], p_r[3]};
          default: ;
        endcase
        sgl_ra = (cmd.term == cwic_pkg::TERM_S2) ? {cmd.outer_cmp, x_r[0]}
                                                 : {cmd.outer_cmp, x_r[1]};
        tau_ra = {cmd.outer_cmp, cmd.inner_cmp, x_r[0], x_r[1]};
      end
      default: begin
        case (cmd.term)
          cwic_pkg::TERM_F:  int_ra = {p_r[0], p_r[1], p_r[2], cmd.outer_idx};
          cwic_pkg::TERM_CF: int_ra = {p_r[0], cmd.inner_idx, p_r[2], cmd.outer_idx};
          cwic_pkg::TERM_N:  int_ra = {p_r[0], cmd.outer_idx, p_r[2], p_r[3]};
          default: ;
        endcase
        if (cmd.term == cwic_pkg::TERM_N) begin
          sgl_ra = {cmd.outer_cmp, x_r[1]};
        end else if (cmd.term == cwic_pkg::TERM_CF && cmd.sub) begin
          sgl_ra = {cmd.inner_cmp, x_r[1]};
        end
      end
    endcase
  end

  // stores with one write and one read port, writes only while idle
  always_ff @(posedge clk) begin
    if (wr && in_operation == cwic_pkg::OP_WR_INT) int_mem[wa4] <= in_data_value;
    int_q <= int_mem[int_ra];
  end
  always_ff @(posedge clk) begin
    if (wr && in_operation == cwic_pkg::OP_WR_SGL) sgl_mem[wa2] <= in_data_value;
    sgl_q <= sgl_mem[sgl_ra];
  end
  always_ff @(posedge clk) begin
    if (wr && in_operation == cwic_pkg::OP_WR_DBL) dbl_mem[wa4] <= in_data_value;
    dbl_q <= dbl_mem[dbl_ra];
  end
  always_ff @(posedge clk) begin
    if (wr && in_operation == cwic_pkg::OP_WR_TAU) tau_mem[wa4] <= in_data_value;
    tau_q <= tau_mem[tau_ra];
  end

  always_comb begin
    case (cmd.op)
      cwic_pkg::DP_MUL_T1: begin mul_a = t1a_r; mul_b = sgl_q; end
      cwic_pkg::DP_MUL_C:  begin mul_a = c24_r; mul_b = int_r; end
      default: begin
        mul_a = (cmd.term == cwic_pkg::TERM_TAU) ? tau_q : sgl_q;
        mul_b = int_q;
      end
    endcase
    mul_p   = AW'(mul_a) * AW'(mul_b);
    addend  = cmd.neg ? -prod_r : prod_r;
    coef    = (AW'(t2_r) <<< 23) + prod_r + cwic_pkg::HALF_LSB;
    coef_sh = coef >>> cwic_pkg::FRAC_W;
    rnd_sh  = acc_r >>> cwic_pkg::FRAC_W;
    scan_occ = is_occ(cmd.outer_idx, mask_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cwic_pkg::DP_LOAD: begin
        kind_r     <= in_formula_kind;
        x_r[0]     <= in_idx_first;
        x_r[1]     <= in_idx_second;
        x_r[2]     <= in_idx_third;
        x_r[3]     <= in_idx_fourth;
        found_r    <= '0;
        occ_cnt_r  <= '0;
        virt_cnt_r <= '0;
      end
      cwic_pkg::DP_SCAN: begin
        for (int s = 0; s < 4; s++) begin
          if (scan_occ == slot_occ(kind_r, s) &&
              (scan_occ ? occ_cnt_r : virt_cnt_r) == {1'b0, x_r[s]}) begin
            p_r[s]     <= cmd.outer_idx;
            found_r[s] <= 1'b1;
          end
        end
        if (scan_occ) occ_cnt_r <= occ_cnt_r + 1'b1;
        else          virt_cnt_r <= virt_cnt_r + 1'b1;
      end
      cwic_pkg::DP_INIT: begin
        acc_r <= AW'(int_q) <<< cwic_pkg::FRAC_W;
        q_r   <= '0;
      end
      cwic_pkg::DP_MUL, cwic_pkg::DP_MUL_T1, cwic_pkg::DP_MUL_C: prod_r <= mul_p;
      cwic_pkg::DP_CAP: begin
        t2_r  <= dbl_q;
        t1a_r <= sgl_q;
        int_r <= int_q;
      end
      cwic_pkg::DP_COEF: begin
        if (coef_sh > C32_HI)      c24_r <= DW'(C32_HI);
        else if (coef_sh < C32_LO) c24_r <= DW'(C32_LO);
        else                       c24_r <= DW'(coef_sh);
      end
      cwic_pkg::DP_ACC: begin
        if (cmd.to_q) q_r <= cwic_pkg::sadd64(q_r, addend);
        else          acc_r <= cwic_pkg::sadd64(acc_r, addend);
      end
      cwic_pkg::DP_FINAL: acc_r <= cwic_pkg::sadd64(acc_r, q_r >>> 2);
      cwic_pkg::DP_RND:   acc_r <= cwic_pkg::sadd64(acc_r, cwic_pkg::HALF_LSB);
      cwic_pkg::DP_SAT: begin
        if (rnd_sh > SAT_HI)      res_r <= DW'(SAT_HI);
        else if (rnd_sh < SAT_LO) res_r <= DW'(SAT_LO);
        else                      res_r <= DW'(rnd_sh);
        err_r <= 1'b0;
      end
      cwic_pkg::DP_ERR: begin
        res_r <= '0;
        err_r <= 1'b1;
      end
      cwic_pkg::DP_OUT: begin
        out_w_value <= res_r;
        out_status  <= err_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == cwic_pkg::DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.kind      = kind_r;
  assign status.occ_outer = scan_occ;
  assign status.occ_inner = is_occ(cmd.inner_idx, mask_r);
  assign status.found_all = &found_r;
  assign status.out_busy  = out_valid_r && !out_ready;

endmodule

FILE: sv/cwic_ctrl.sv
// ----------------------------------------------------------------------------
// cwic_ctrl
// sequencer: orbital scan, nested orbital loops and term micro-steps
// ----------------------------------------------------------------------------
module cwic_ctrl #(
  parameter int SPIN_ORBITALS = cwic_pkg::SPIN_ORBITALS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [cwic_pkg::OP_W-1:0] in_operation,
  output logic                      in_ready,
  input  cwic_pkg::status_t         status,
  output cwic_pkg::cmd_t            cmd
);

  localparam int IW    = cwic_pkg::IDX_W;
  localparam int ORBS  = (SPIN_ORBITALS < (1 << IW)) ? SPIN_ORBITALS : (1 << IW);
  localparam int CNT_W = $clog2(ORBS + 1);

  cwic_pkg::st_t   state_r, state_nxt;
  cwic_pkg::term_t term_r, term_nxt;
  logic [CNT_W-1:0] o_r, o_nxt, i_r, i_nxt;
  logic [IW-1:0]    ko_r, ko_nxt, ki_r, ki_nxt;
  logic             phase_r, phase_nxt;
  logic             want_outer, want_inner;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwic_pkg::ST_IDLE;
      term_r  <= cwic_pkg::TERM_BASE;
      o_r     <= '0;
      i_r     <= '0;
      ko_r    <= '0;
      ki_r    <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      o_r     <= o_nxt;
      i_r     <= i_nxt;
      ko_r    <= ko_nxt;
      ki_r    <= ki_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign want_outer = (status.kind == cwic_pkg::KIND_ABEF) ||
                      (status.kind == cwic_pkg::KIND_MBEJ && phase_r);
  assign want_inner = (status.kind != cwic_pkg::KIND_MNIJ);

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    o_nxt     = o_r;
    i_nxt     = i_r;
    ko_nxt    = ko_r;
    ki_nxt    = ki_r;
    phase_nxt = phase_r;
    in_ready  = 1'b0;

    cmd           = '0;
    cmd.op        = cwic_pkg::DP_NOP;
    cmd.term      = term_r;
    cmd.outer_idx = IW'(o_r);
    cmd.outer_cmp = ko_r;
    cmd.inner_idx = IW'(i_r);
    cmd.inner_cmp = ki_r;
    cmd.to_q      = (term_r == cwic_pkg::TERM_TAU);
    unique case (term_r)
      cwic_pkg::TERM_S1: cmd.neg = (status.kind == cwic_pkg::KIND_ABEF);
      cwic_pkg::TERM_S2: cmd.neg = (status.kind == cwic_pkg::KIND_MNIJ);
      cwic_pkg::TERM_CF, cwic_pkg::TERM_N: cmd.neg = 1'b1;
      default: cmd.neg = 1'b0;
    endcase

    unique case (state_r)
      cwic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == cwic_pkg::OP_COMPUTE) begin
            cmd.op    = cwic_pkg::DP_LOAD;
            o_nxt     = '0;
            state_nxt = cwic_pkg::ST_SCAN;
          end else if (in_operation < cwic_pkg::OP_COMPUTE) begin
            cmd.op = cwic_pkg::DP_WRITE;
          end
        end
      end
      cwic_pkg::ST_SCAN: begin
        cmd.op = cwic_pkg::DP_SCAN;
        if (o_r == CNT_W'(ORBS - 1)) begin
          o_nxt     = '0;
          state_nxt = cwic_pkg::ST_CHECK;
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      cwic_pkg::ST_CHECK: begin
        if (status.kind != cwic_pkg::KIND_MNIJ && status.kind != cwic_pkg::KIND_ABEF &&
            status.kind != cwic_pkg::KIND_MBEJ) begin
          state_nxt = cwic_pkg::ST_ERR;
        end else if (!status.found_all) begin
          state_nxt = cwic_pkg::ST_ERR;
        end else begin
          term_nxt  = cwic_pkg::TERM_BASE;
          state_nxt = cwic_pkg::ST_BASE_RD;
        end
      end
      cwic_pkg::ST_ERR: begin
        cmd.op    = cwic_pkg::DP_ERR;
        state_nxt = cwic_pkg::ST_FINISH;
      end
      cwic_pkg::ST_BASE_RD: state_nxt = cwic_pkg::ST_INIT;
      cwic_pkg::ST_INIT: begin
        cmd.op    = cwic_pkg::DP_INIT;
        o_nxt     = '0;
        ko_nxt    = '0;
        phase_nxt = 1'b0;
        state_nxt = cwic_pkg::ST_OUTER;
      end
      cwic_pkg::ST_OUTER: begin
        if (o_r == CNT_W'(ORBS)) begin
          if (status.kind == cwic_pkg::KIND_MBEJ && !phase_r) begin
            phase_nxt = 1'b1;
            o_nxt     = '0;
            ko_nxt    = '0;
          end else begin
            state_nxt = cwic_pkg::ST_FINAL;
          end
        end else if (status.occ_outer == want_outer) begin
          if (status.kind == cwic_pkg::KIND_MBEJ) begin
            term_nxt = phase_r ? cwic_pkg::TERM_N : cwic_pkg::TERM_F;
          end else begin
            term_nxt = cwic_pkg::TERM_S1;
          end
          state_nxt = cwic_pkg::ST_T_RD;
        end else begin
          o_nxt = o_r + 1'b1;
        end
      end
      cwic_pkg::ST_T_RD: state_nxt = cwic_pkg::ST_T_MUL;
      cwic_pkg::ST_T_MUL: begin
        cmd.op    = cwic_pkg::DP_MUL;
        state_nxt = cwic_pkg::ST_T_ACC;
      end
      cwic_pkg::ST_T_ACC: begin
        cmd.op = cwic_pkg::DP_ACC;
        case (term_r)
          cwic_pkg::TERM_S1: begin
            term_nxt  = cwic_pkg::TERM_S2;
            state_nxt = cwic_pkg::ST_T_RD;
          end
          cwic_pkg::TERM_S2, cwic_pkg::TERM_F: begin
            i_nxt     = '0;
            ki_nxt    = '0;
            state_nxt = cwic_pkg::ST_INNER;
          end
          cwic_pkg::TERM_TAU, cwic_pkg::TERM_CF: begin
            i_nxt     = i_r + 1'b1;
            ki_nxt    = ki_r + 1'b1;
            state_nxt = cwic_pkg::ST_INNER;
          end
          default: begin
            o_nxt     = o_r + 1'b1;
            ko_nxt    = ko_r + 1'b1;
            state_nxt = cwic_pkg::ST_OUTER;
          end
        endcase
      end
      cwic_pkg::ST_INNER: begin
        if (i_r == CNT_W'(ORBS)) begin
          o_nxt     = o_r + 1'b1;
          ko_nxt    = ko_r + 1'b1;
          state_nxt = cwic_pkg::ST_OUTER;
        end else if (status.occ_inner == want_inner) begin
          if (status.kind == cwic_pkg::KIND_MBEJ) begin
            term_nxt  = cwic_pkg::TERM_CF;
            state_nxt = cwic_pkg::ST_C_RD1;
          end else begin
            term_nxt  = cwic_pkg::TERM_TAU;
            state_nxt = cwic_pkg::ST_T_RD;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      // coefficient term: t2 and first singles, then second singles
      cwic_pkg::ST_C_RD1: state_nxt = cwic_pkg::ST_C_RD2;
      cwic_pkg::ST_C_RD2: begin
        cmd.op    = cwic_pkg::DP_CAP;
        cmd.sub   = 1'b1;
        state_nxt = cwic_pkg::ST_C_MUL1;
      end
      cwic_pkg::ST_C_MUL1: begin
        cmd.op    = cwic_pkg::DP_MUL_T1;
        state_nxt = cwic_pkg::ST_C_COEF;
      end
      cwic_pkg::ST_C_COEF: begin
        cmd.op    = cwic_pkg::DP_COEF;
        state_nxt = cwic_pkg::ST_C_MUL2;
      end
      cwic_pkg::ST_C_MUL2: begin
        cmd.op    = cwic_pkg::DP_MUL_C;
        state_nxt = cwic_pkg::ST_T_ACC;
      end
      cwic_pkg::ST_FINAL: begin
        cmd.op    = cwic_pkg::DP_FINAL;
        state_nxt = cwic_pkg::ST_RND;
      end
      cwic_pkg::ST_RND: begin
        cmd.op    = cwic_pkg::DP_RND;
        state_nxt = cwic_pkg::ST_SAT;
      end
      cwic_pkg::ST_SAT: begin
        cmd.op    = cwic_pkg::DP_SAT;
        state_nxt = cwic_pkg::ST_FINISH;
      end
      cwic_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.op    = cwic_pkg::DP_OUT;
          state_nxt = cwic_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cwic_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/ccsd_w_intermediate_contraction_core.sv
// ----------------------------------------------------------------------------
// ccsd_w_intermediate_contraction_core
// returns one element of the wmnij, wabef or wmbej intermediate from four stores
// ----------------------------------------------------------------------------
// store writes: one transaction per cycle while the sequencer is idle, no result
// compute: orbital scan and setup, then a walk over the orbital positions with
//   each product term (and each wmbej coefficient term) on the shared
//   multiplier, then final sum, rounding, saturation and output
// one compute at a time; the next transaction is taken while a result waits
// rst_n (synchronous) clears the sequencer, output valid and occupied mask;
//   store contents are undefined until written

module ccsd_w_intermediate_contraction_core #(
  parameter int SPIN_ORBITALS = cwic_pkg::SPIN_ORBITALS_DEF,
  parameter int VALUE_BITS    = cwic_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cwic_pkg::MASK_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cwic_pkg::OP_W-1:0]          in_operation,
  input  logic [cwic_pkg::KIND_W-1:0]        in_formula_kind,
  input  logic [cwic_pkg::IDX_W-1:0]         in_idx_first,
  input  logic [cwic_pkg::IDX_W-1:0]         in_idx_second,
  input  logic [cwic_pkg::IDX_W-1:0]         in_idx_third,
  input  logic [cwic_pkg::IDX_W-1:0]         in_idx_fourth,
  input  logic signed [cwic_pkg::DATA_W-1:0] in_data_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cwic_pkg::DATA_W-1:0] out_w_value,
  output logic                               out_status
);

  cwic_pkg::cmd_t    cmd;
  cwic_pkg::status_t status;

  cwic_ctrl #(
    .SPIN_ORBITALS(SPIN_ORBITALS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  cwic_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_operation),
    .in_formula_kind (in_formula_kind),
    .in_idx_first    (in_idx_first),
    .in_idx_second   (in_idx_second),
    .in_idx_third    (in_idx_third),
    .in_idx_fourth   (in_idx_fourth),
    .in_data_value   (in_data_value),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_w_value     (out_w_value),
    .out_status      (out_status)
  );

endmodule

FILE: sv/cwic_checker.sv
// ----------------------------------------------------------------------------
// cwic_checker
// port-level checks for the w-intermediate core, bound to the top level
// ----------------------------------------------------------------------------
module cwic_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [cwic_pkg::OP_W-1:0]          in_operation,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [cwic_pkg::DATA_W-1:0] out_w_value,
  input logic                               out_status
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_w_value) && $stable(out_status))
    else $error("result changed while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_w_value == '0)
    else $error("error result with nonzero value");

  // a store write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation != cwic_pkg::OP_COMPUTE |=> !$rose(out_valid))
    else $error("result after store write");

  // a compute transaction occupies the engine
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == cwic_pkg::OP_COMPUTE |=> !in_ready)
    else $error("input taken during compute");

endmodule

bind ccsd_w_intermediate_contraction_core cwic_checker u_cwic_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_w_value  (out_w_value),
  .out_status   (out_status)
);

FILE: tb/w_element_checker.sv
// ----------------------------------------------------------------------------
// w_element_checker
// watches the store and compute transactions of the w-intermediate core, keeps
// its own copy of the four stores and the occupied mask, predicts every result
// and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module w_element_checker
  import cwic_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [MASK_W-1:0]         cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [KIND_W-1:0]         in_formula_kind,
  input  logic [IDX_W-1:0]          in_idx_first,
  input  logic [IDX_W-1:0]          in_idx_second,
  input  logic [IDX_W-1:0]          in_idx_third,
  input  logic [IDX_W-1:0]          in_idx_fourth,
  input  logic signed [DATA_W-1:0]  in_data_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DATA_W-1:0]  out_w_value,
  input  logic                      out_status,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [DATA_W-1:0] w;
    logic              st;
  } w_result_t;

  localparam longint Q24_ONE = 64'sd16777216;
  localparam longint Q24_HALF = 64'sd8388608;

  w_result_t         expected_w[$];
  bit [DATA_W-1:0]   integral_mem[65536];
  bit [DATA_W-1:0]   singles_mem[256];
  bit [DATA_W-1:0]   doubles_mem[65536];
  bit [DATA_W-1:0]   tau_mem[65536];
  logic [MASK_W-1:0] occ_mask = '0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic longint sx(bit [DATA_W-1:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if ((a < 0) == (b < 0) && (s < 0) != (a < 0)) s = (a < 0) ? ACC_MIN : ACC_MAX;
    return s;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic bit is_occ(int p);
    return occ_mask[p >> 1];
  endfunction

  // compact index to spin orbital, -1 past the count
  function automatic int orbital(int k, bit want_occ);
    int c;
    c = 0;
    for (int p = 0; p < 16; p++) begin
      if (is_occ(p) != want_occ) continue;
      if (c == k) return p;
      c++;
    end
    return -1;
  endfunction

  function automatic int addr4(int a, int b, int c, int d);
    return ((a & 15) << 12) | ((b & 15) << 8) | ((c & 15) << 4) | (d & 15);
  endfunction

  function automatic longint ints(int p, int q, int r, int s);
    return sx(integral_mem[addr4(p, q, r, s)]);
  endfunction

  function automatic longint t1(int i, int a);
    return sx(singles_mem[((i & 15) << 4) | (a & 15)]);
  endfunction

  function automatic w_result_t predict_w_element(logic [KIND_W-1:0] kind,
                                                  int x0, int x1, int x2, int x3);
    bit [3:0]  occ_pat;
    int        p0, p1, p2, p3, ke, kf, km, kn;
    longint    acc, q, c, c24, r;
    w_result_t res;
    res = '{w: '0, st: 1'b1};
    case (kind)
      KIND_MNIJ: occ_pat = 4'b1111;
      KIND_ABEF: occ_pat = 4'b0000;
      KIND_MBEJ: occ_pat = 4'b1001;
      default:   return res;
    endcase
    p0 = orbital(x0, occ_pat[3]);
    p1 = orbital(x1, occ_pat[2]);
    p2 = orbital(x2, occ_pat[1]);
    p3 = orbital(x3, occ_pat[0]);
    if (p0 < 0 || p1 < 0 || p2 < 0 || p3 < 0) return res;
    acc = ints(p0, p1, p2, p3) * Q24_ONE;
    q = 0;
    if (kind == KIND_MNIJ) begin
      ke = 0;
      for (int e = 0; e < 16; e++) begin
        if (is_occ(e)) continue;
        acc = sat_add(acc, t1(x3, ke) * ints(p0, p1, p2, e));
        acc = sat_add(acc, -(t1(x2, ke) * ints(p0, p1, p3, e)));
        kf = 0;
        for (int f = 0; f < 16; f++) begin
          if (is_occ(f)) continue;
          q = sat_add(q, sx(tau_mem[addr4(x2, x3, ke, kf)]) * ints(p0, p1, e, f));
          kf++;
        end
        ke++;
      end
      acc = sat_add(acc, q >>> 2);
    end else if (kind == KIND_ABEF) begin
      km = 0;
      for (int m = 0; m < 16; m++) begin
        if (!is_occ(m)) continue;
        acc = sat_add(acc, -(t1(km, x1) * ints(p0, m, p2, p3)));
        acc = sat_add(acc, t1(km, x0) * ints(p1, m, p2, p3));
        kn = 0;
        for (int n = 0; n < 16; n++) begin
          if (!is_occ(n)) continue;
          q = sat_add(q, sx(tau_mem[addr4(km, kn, x0, x1)]) * ints(m, n, p2, p3));
          kn++;
        end
        km++;
      end
      acc = sat_add(acc, q >>> 2);
    end else begin
      kf = 0;
      for (int f = 0; f < 16; f++) begin
        if (is_occ(f)) continue;
        acc = sat_add(acc, t1(x3, kf) * ints(p0, p1, p2, f));
        kn = 0;
        for (int n = 0; n < 16; n++) begin
          if (!is_occ(n)) continue;
          // half doubles plus product of singles, rounded to q24 before use
          c = sx(doubles_mem[addr4(x3, kn, kf, x1)]) * Q24_HALF + t1(x3, kf) * t1(kn, x1);
          c24 = sat32((c + Q24_HALF) >>> 24);
          acc = sat_add(acc, -(c24 * ints(p0, n, p2, f)));
          kn++;
        end
        kf++;
      end
      kn = 0;
      for (int n = 0; n < 16; n++) begin
        if (!is_occ(n)) continue;
        acc = sat_add(acc, -(t1(kn, x1) * ints(p0, n, p2, p3)));
        kn++;
      end
    end
    r = sat32(sat_add(acc, Q24_HALF) >>> 24);
    res.w = r[DATA_W-1:0];
    res.st = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    w_result_t exp_r;
    int        a;
    if (!rst_n) begin
      occ_mask = '0;
      expected_w.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_w.size() == 0) begin
          $display("%0t: unexpected result w_value=%h status=%b", $time, out_w_value,
                   out_status);
          fail_count++;
        end else begin
          exp_r = expected_w.pop_front();
          if (out_w_value !== exp_r.w) begin
            $display("%0t: w_value expected %h actual %h", $time, exp_r.w, out_w_value);
            fail_count++;
          end
          if (out_status !== exp_r.st) begin
            $display("%0t: status expected %b actual %b", $time, exp_r.st, out_status);
            fail_count++;
          end
        end
      end
      if (cfg_we) occ_mask = cfg_wdata;
      if (in_valid && in_ready) begin
        a = addr4(in_idx_first, in_idx_second, in_idx_third, in_idx_fourth);
        case (in_operation)
          OP_WR_INT: integral_mem[a] = in_data_value;
          OP_WR_SGL: singles_mem[{in_idx_first, in_idx_second}] = in_data_value;
          OP_WR_DBL: doubles_mem[a] = in_data_value;
          OP_WR_TAU: tau_mem[a] = in_data_value;
          OP_COMPUTE: expected_w.push_back(predict_w_element(in_formula_kind,
              in_idx_first, in_idx_second, in_idx_third, in_idx_fourth));
          default: ;
        endcase
      end
    end
    pending = expected_w.size();
  end

endmodule

FILE: tb/ccsd_w_intermediate_contraction_core_test.sv
// ----------------------------------------------------------------------------
// ccsd_w_intermediate_contraction_core_test
// drives store writes and element queries into the w-intermediate core under
// several occupied masks, with random idling on both channels and one long
// output stall; every store entry a query reads is written first
// ----------------------------------------------------------------------------
module ccsd_w_intermediate_contraction_core_test;
  import cwic_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;
  localparam logic [OP_W-1:0]   OP_UNUSED_LO = 3'd5;
  localparam int                ITEM_TARGET  = 1170;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [KIND_W-1:0] in_formula_kind = '0;
  logic [IDX_W-1:0] in_idx_first = '0, in_idx_second = '0;
  logic [IDX_W-1:0] in_idx_third = '0, in_idx_fourth = '0;
  logic signed [DATA_W-1:0] in_data_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_w_value;
  logic out_status;
  int fail_count, pending;

  bit [MASK_W-1:0] cur_mask;
  bit integral_wr[65536], singles_wr[256], doubles_wr[65536], tau_wr[65536];
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int hold_left = 0, gap_left = 0;
  int items = 0;

  ccsd_w_intermediate_contraction_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_formula_kind(in_formula_kind), .in_idx_first(in_idx_first),
    .in_idx_second(in_idx_second), .in_idx_third(in_idx_third),
    .in_idx_fourth(in_idx_fourth), .in_data_value(in_data_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_w_value(out_w_value),
    .out_status(out_status)
  );

  w_element_checker i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_formula_kind(in_formula_kind), .in_idx_first(in_idx_first),
    .in_idx_second(in_idx_second), .in_idx_third(in_idx_third),
    .in_idx_fourth(in_idx_fourth), .in_data_value(in_data_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_w_value(out_w_value),
    .out_status(out_status), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // receiver: long hold on request, otherwise short random bursts
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (gap_left > 0) begin
      out_ready = 1'b0;
      gap_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      gap_left = $urandom_range(0, 4);
    end else begin
      out_ready = 1'b1;
    end
  end

  initial begin
    #60_000_000;
    $display("ccsd_w_intermediate_contraction_core_test failed");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h01FF_FFFF);
      3: return -$urandom_range(0, 32'h01FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic int orbital(int k, bit want_occ);
    int c;
    c = 0;
    for (int p = 0; p < 16; p++) begin
      if (cur_mask[p >> 1] != want_occ) continue;
      if (c == k) return p;
      c++;
    end
    return -1;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind, int a, int b,
                      int c, int d, logic [DATA_W-1:0] v);
    int adr;
    adr = ((a & 15) << 12) | ((b & 15) << 8) | ((c & 15) << 4) | (d & 15);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_operation = op;
    in_formula_kind = kind;
    in_idx_first = a;
    in_idx_second = b;
    in_idx_third = c;
    in_idx_fourth = d;
    in_data_value = v;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items++;
    case (op)
      OP_WR_INT: integral_wr[adr] = 1'b1;
      OP_WR_SGL: singles_wr[((a & 15) << 4) | (b & 15)] = 1'b1;
      OP_WR_DBL: doubles_wr[adr] = 1'b1;
      OP_WR_TAU: tau_wr[adr] = 1'b1;
      default: ;
    endcase
  endtask

  // write a store entry first if a query is about to read it
  task automatic need(logic [OP_W-1:0] op, int a, int b, int c, int d);
    int adr;
    bit done;
    adr = ((a & 15) << 12) | ((b & 15) << 8) | ((c & 15) << 4) | (d & 15);
    case (op)
      OP_WR_INT: done = integral_wr[adr];
      OP_WR_SGL: done = singles_wr[((a & 15) << 4) | (b & 15)];
      OP_WR_DBL: done = doubles_wr[adr];
      default:   done = tau_wr[adr];
    endcase
    if (!done) send(op, KIND_MNIJ, a, b, c, d, rand_value());
  endtask

  task automatic query(logic [KIND_W-1:0] kind, int x0, int x1, int x2, int x3);
    int p0, p1, p2, p3, k1, k2;
    p0 = -1;
    case (kind)
      KIND_MNIJ: begin
        p0 = orbital(x0, 1); p1 = orbital(x1, 1); p2 = orbital(x2, 1); p3 = orbital(x3, 1);
      end
      KIND_ABEF: begin
        p0 = orbital(x0, 0); p1 = orbital(x1, 0); p2 = orbital(x2, 0); p3 = orbital(x3, 0);
      end
      KIND_MBEJ: begin
        p0 = orbital(x0, 1); p1 = orbital(x1, 0); p2 = orbital(x2, 0); p3 = orbital(x3, 1);
      end
      default: ;
    endcase
    if (p0 >= 0 && p1 >= 0 && p2 >= 0 && p3 >= 0) begin
      need(OP_WR_INT, p0, p1, p2, p3);
      k1 = 0;
      for (int e = 0; e < 16; e++) begin
        if (cur_mask[e >> 1] != (kind == KIND_ABEF)) continue;
        k2 = 0;
        case (kind)
          KIND_MNIJ: begin
            need(OP_WR_SGL, x3, k1, 0, 0);
            need(OP_WR_INT, p0, p1, p2, e);
            need(OP_WR_SGL, x2, k1, 0, 0);
            need(OP_WR_INT, p0, p1, p3, e);
          end
          KIND_ABEF: begin
            need(OP_WR_SGL, k1, x1, 0, 0);
            need(OP_WR_INT, p0, e, p2, p3);
            need(OP_WR_SGL, k1, x0, 0, 0);
            need(OP_WR_INT, p1, e, p2, p3);
          end
          default: begin
            need(OP_WR_SGL, x3, k1, 0, 0);
            need(OP_WR_INT, p0, p1, p2, e);
          end
        endcase
        for (int f = 0; f < 16; f++) begin
          if (cur_mask[f >> 1] != (kind != KIND_MNIJ)) continue;
          case (kind)
            KIND_MNIJ: begin
              need(OP_WR_TAU, x2, x3, k1, k2);
              need(OP_WR_INT, p0, p1, e, f);
            end
            KIND_ABEF: begin
              need(OP_WR_TAU, k1, k2, x0, x1);
              need(OP_WR_INT, e, f, p2, p3);
            end
            default: begin
              need(OP_WR_DBL, x3, k2, k1, x1);
              need(OP_WR_SGL, k2, x1, 0, 0);
              need(OP_WR_INT, p0, f, p2, e);
            end
          endcase
          k2++;
        end
        k1++;
      end
      if (kind == KIND_MBEJ) begin
        k2 = 0;
        for (int n = 0; n < 16; n++) begin
          if (!cur_mask[n >> 1]) continue;
          need(OP_WR_SGL, k2, x1, 0, 0);
          need(OP_WR_INT, p0, n, p2, p3);
          k2++;
        end
      end
    end
    send(OP_COMPUTE, kind, x0, x1, x2, x3, $urandom);
  endtask

  task automatic set_mask(bit [MASK_W-1:0] m);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    cur_mask = m;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_query();
    int nocc, nvir, k;
    logic [KIND_W-1:0] kind;
    int x[4];
    bit [3:0] pat;
    nocc = 2 * $countones(cur_mask);
    nvir = 16 - nocc;
    k = $urandom_range(0, 9);
    kind = (k == 9) ? KIND_BAD : logic'(k % 3);
    pat = (kind == KIND_MNIJ) ? 4'b1111 : (kind == KIND_ABEF) ? 4'b0000 : 4'b1001;
    for (int i = 0; i < 4; i++) begin
      k = pat[3 - i] ? nocc : nvir;
      if (k > 0 && $urandom_range(0, 7) != 0) x[i] = $urandom_range(0, k - 1);
      else x[i] = $urandom_range(0, 15);
    end
    query(kind, x[0], x[1], x[2], x[3]);
  endtask

  initial begin
    bit [MASK_W-1:0] m;
    int phase_end;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, out-of-range and bad kind
    set_mask(8'h0F);
    send(OP_WR_INT, KIND_MNIJ, 15, 15, 15, 15, 32'h7FFF_FFFF);
    send(OP_WR_INT, KIND_MNIJ, 0, 0, 0, 0, 32'h8000_0000);
    send(OP_WR_SGL, KIND_MNIJ, 0, 0, 15, 15, 32'h7FFF_FFFF);
    send(OP_WR_DBL, KIND_MNIJ, 15, 15, 15, 15, 32'h8000_0000);
    send(OP_WR_TAU, KIND_MNIJ, 15, 15, 15, 15, 32'h0100_0000);
    query(KIND_MNIJ, 0, 1, 2, 3);
    query(KIND_ABEF, 7, 6, 0, 1);
    query(KIND_MBEJ, 7, 0, 7, 0);
    query(KIND_MNIJ, 15, 0, 0, 0);
    query(KIND_ABEF, 0, 0, 0, 8);
    query(KIND_BAD, 15, 15, 15, 15);
    send(OP_UNUSED_LO, KIND_MNIJ, 1, 2, 3, 4, 32'h1234_5678);
    send(OP_UNUSED_LO + 3'd2, KIND_BAD, 15, 15, 15, 15, 32'hFFFF_FFFF);
    set_mask(8'h00);
    query(KIND_ABEF, 15, 0, 15, 0);
    query(KIND_MNIJ, 0, 0, 0, 0);
    set_mask(8'hFF);
    query(KIND_MNIJ, 15, 0, 15, 0);
    query(KIND_MBEJ, 0, 0, 0, 0);

    // the block holds one result and then stalls its input
    set_mask(8'h3C);
    long_hold_req = 1'b1;
    @(negedge clk);
    repeat (4) query(KIND_MBEJ, 1, 2, 3, 0);

    while (items < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: m = 8'h00;
        1: m = 8'hFF;
        default: m = $urandom;
      endcase
      set_mask(m);
      phase_end = items + 150;
      while (items < phase_end && items < ITEM_TARGET) begin
        if (items > ITEM_TARGET - 150) quiet = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: random_query();
          4: send(OP_UNUSED_LO + $urandom_range(0, 2), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
          default: send($urandom_range(OP_WR_INT, OP_WR_TAU), $urandom, $urandom,
                        $urandom, $urandom, $urandom, rand_value());
        endcase
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("ccsd_w_intermediate_contraction_core_test passed");
    end else begin
      $display("ccsd_w_intermediate_contraction_core_test failed");
    end
    $finish;
  end

endmodule
